### hdl/kpi_pkg.sv
// Shared types and constants for the keyframe pose interpolator.
package kpi_pkg;

  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_POSE  = 3'd1;
  localparam logic [2:0] OP_HDR   = 3'd2;
  localparam logic [2:0] OP_START = 3'd3;
  localparam logic [2:0] OP_SET   = 3'd4;

  localparam logic [1:0] CFG_NEUTRAL = 2'd0;
  localparam logic [1:0] CFG_BLEND   = 2'd1;
  localparam logic [1:0] CFG_LOOP    = 2'd2;

  localparam int PI_Q      = 12868;
  localparam int TWO_PI_Q  = 25736;
  localparam int POS_MAX   = 524287;
  localparam int POS_MIN   = -524288;
  localparam int ROT_MAX   = 32767;
  localparam int ROT_MIN   = -32768;
  localparam int DIV_STEPS = 12;
  localparam int CNT_MAX   = 2047;

  typedef logic signed [19:0] pos_t;
  typedef logic signed [15:0] rot_t;

  typedef struct packed {
    pos_t [2:0] pos;
    rot_t [2:0] rot;
  } pose_t;

  typedef enum logic [3:0] {
    S_IDLE, S_HDR, S_DIV, S_RDF, S_RDT, S_DLT, S_MUL, S_OUT, S_UPD, S_SRD, S_SWR
  } state_e;

  typedef struct packed {
    logic accept;
    logic hdr;
    logic div_step;
    logic rd_to;
    logic rd_start;
    logic take_delta;
    logic take_prod;
    logic out_ld;
    logic upd;
    logic start_wr;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic part_last;
    logic out_free;
  } sts_t;

endpackage

### hdl/kpi_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kpi_ram #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/kpi_ctrl.sv
// Sequencer for the keyframe pose interpolator.
module kpi_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [2:0]    opcode_i,
  input  kpi_pkg::sts_t sts_i,
  output kpi_pkg::cmd_t cmd_o,
  output logic          in_stall_o
);
  import kpi_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (opcode_i == OP_TICK) begin
            state_d = S_HDR;
          end else if (opcode_i == OP_START) begin
            state_d = S_SRD;
          end
        end
      end
      S_HDR: state_d = S_DIV;
      S_DIV: begin
        if (sts_i.div_last) state_d = S_RDF;
      end
      S_RDF: state_d = S_RDT;
      S_RDT: state_d = S_DLT;
      S_DLT: state_d = S_MUL;
      S_MUL: state_d = S_OUT;
      S_OUT: begin
        if (sts_i.out_free) state_d = sts_i.part_last ? S_UPD : S_RDF;
      end
      S_UPD: state_d = S_IDLE;
      S_SRD: state_d = S_SWR;
      S_SWR: state_d = sts_i.part_last ? S_IDLE : S_SRD;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: cmd_o.accept     = in_valid_i;
      S_HDR:  cmd_o.hdr        = 1'b1;
      S_DIV:  cmd_o.div_step   = 1'b1;
      S_RDT:  cmd_o.rd_to      = 1'b1;
      S_DLT:  cmd_o.take_delta = 1'b1;
      S_MUL:  cmd_o.take_prod  = 1'b1;
      S_OUT:  cmd_o.out_ld     = sts_i.out_free;
      S_UPD:  cmd_o.upd        = 1'b1;
      S_SRD:  cmd_o.rd_start   = 1'b1;
      S_SWR:  cmd_o.start_wr   = 1'b1;
      default: cmd_o = '0;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

### hdl/kpi_dp.sv
// Datapath: key tables, pose registers, weight divider and channel arithmetic.
module kpi_dp #(
  parameter int PARTS   = 16,
  parameter int KEYS    = 16,
  parameter int MOTIONS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  kpi_pkg::cmd_t        cmd_i,
  output kpi_pkg::sts_t        sts_o,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [9:0]           cfg_data_i,
  input  logic [2:0]           opcode_i,
  input  logic [2:0]           motion_i,
  input  logic [3:0]           key_i,
  input  logic [3:0]           part_i,
  input  logic signed [19:0]   pos_x_i,
  input  logic signed [19:0]   pos_y_i,
  input  logic signed [19:0]   pos_z_i,
  input  logic signed [15:0]   rot_x_i,
  input  logic signed [15:0]   rot_y_i,
  input  logic signed [15:0]   rot_z_i,
  input  logic [9:0]           frame_count_i,
  input  logic [4:0]           key_total_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output logic [3:0]           out_part_o,
  output logic signed [19:0]   out_pos_x_o,
  output logic signed [19:0]   out_pos_y_o,
  output logic signed [19:0]   out_pos_z_o,
  output logic signed [15:0]   out_rot_x_o,
  output logic signed [15:0]   out_rot_y_o,
  output logic signed [15:0]   out_rot_z_o,
  output logic                 last_part_o,
  output logic [2:0]           active_motion_o,
  output logic                 blending_o
);
  import kpi_pkg::*;

  localparam int PW  = (PARTS > 1) ? $clog2(PARTS) : 1;
  localparam int MW  = (MOTIONS > 1) ? $clog2(MOTIONS) : 1;
  localparam int KTW = $clog2(KEYS + 1);
  localparam int AW  = $clog2(MOTIONS * KEYS * PARTS);
  localparam int LAW = $clog2(MOTIONS * KEYS);

  // configuration
  logic [2:0] neutral_q;
  logic [9:0] bframes_q;
  logic [7:0] loop_q;

  // sequencing state
  logic [MW-1:0]  cm_q, cm_d;
  logic [4:0]     ck_q, ck_d;
  logic [10:0]    tc_q, tc_d;
  logic [9:0]     span_q, span_d;
  logic           blend_q, blend_d;
  logic           enter;
  logic [KTW-1:0] kt_q [MOTIONS];

  // per-tick working registers
  logic [9:0]  klen_q, len_q, rem_q;
  logic [11:0] quo_q;
  logic [3:0]  dcnt_q;
  logic        wsat_q, wzero_q;
  logic [PW-1:0] part_q;
  pose_t       from_q;
  logic signed [20:0] dpos_q [3];
  logic signed [15:0] drot_q [3];
  logic signed [34:0] ppos_q [3];
  logic signed [29:0] prot_q [3];
  logic [12:0] w;

  pose_t shown_q [PARTS];
  pose_t start_q [PARTS];

  // output register
  logic        ov_q;
  pose_t       opose_q;
  logic [3:0]  opart_q;
  logic        olast_q;
  logic [2:0]  omot_q;
  logic        oblend_q;

  // memories
  logic          pose_we;
  logic [AW-1:0] pose_waddr, pose_raddr;
  pose_t         pose_wdata, pose_rdata;
  logic          len_we;
  logic [LAW-1:0] len_waddr, len_raddr;
  logic [9:0]    len_rdata;

  logic [MW-1:0] neutral_idx;
  logic [AW-1:0] from_addr, to_addr, st_addr;
  logic          part_last;
  logic          loops;
  pose_t         res_pose;
  logic signed [20:0] dpos_d [3];
  logic signed [15:0] drot_d [3];

  assign neutral_idx = (int'(neutral_q) < MOTIONS) ? MW'(neutral_q) : MW'(MOTIONS - 1);
  assign part_last   = (int'(part_q) == PARTS - 1);
  assign loops       = (int'(cm_q) < 8) && loop_q[3'(cm_q)];

  always_comb begin
    int kidx;
    int nk;
    int nxt;
    kidx = (int'(ck_q) < KEYS) ? int'(ck_q) : KEYS - 1;
    nk   = int'(kt_q[cm_q]);
    nxt  = (int'(ck_q) >= nk - 1) ? 0 : int'(ck_q) + 1;
    if (nxt >= KEYS) nxt = KEYS - 1;
    if (blend_q) nxt = 0;
    from_addr = AW'((int'(cm_q) * KEYS + kidx) * PARTS + int'(part_q));
    to_addr   = AW'((int'(cm_q) * KEYS + nxt) * PARTS + int'(part_q));
    st_addr   = AW'(int'(neutral_idx) * KEYS * PARTS + int'(part_q));
    len_raddr = LAW'(int'(cm_q) * KEYS + kidx);
  end

  assign pose_raddr = cmd_i.rd_start ? st_addr : (cmd_i.rd_to ? to_addr : from_addr);

  // table writes
  assign pose_we = cmd_i.accept && (opcode_i == OP_POSE) && (int'(motion_i) < MOTIONS)
                   && (int'(key_i) < KEYS) && (int'(part_i) < PARTS);
  assign pose_waddr = AW'((int'(motion_i) * KEYS + int'(key_i)) * PARTS + int'(part_i));
  always_comb begin
    pose_wdata.pos[0] = pos_x_i;
    pose_wdata.pos[1] = pos_y_i;
    pose_wdata.pos[2] = pos_z_i;
    pose_wdata.rot[0] = rot_x_i;
    pose_wdata.rot[1] = rot_y_i;
    pose_wdata.rot[2] = rot_z_i;
  end
  assign len_we = cmd_i.accept && (opcode_i == OP_HDR) && (int'(motion_i) < MOTIONS)
                  && (int'(key_i) < KEYS);
  assign len_waddr = LAW'(int'(motion_i) * KEYS + int'(key_i));

  kpi_ram #(.Width($bits(pose_t)), .Depth(MOTIONS * KEYS * PARTS)) u_pose_ram (
    .clk_i   (clk_i),
    .we_i    (pose_we),
    .waddr_i (pose_waddr),
    .wdata_i (pose_wdata),
    .raddr_i (pose_raddr),
    .rdata_o (pose_rdata)
  );

  kpi_ram #(.Width(10), .Depth(MOTIONS * KEYS)) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (len_we),
    .waddr_i (len_waddr),
    .wdata_i (frame_count_i),
    .raddr_i (len_raddr),
    .rdata_o (len_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (len_we) begin
      kt_q[MW'(motion_i)] <= (int'(key_total_i) > KEYS) ? KTW'(KEYS) : KTW'(key_total_i);
    end
  end

  // sequencing state update
  always_comb begin
    logic [10:0] tc1;
    logic [4:0]  ck1;
    int nk;
    cm_d    = cm_q;
    ck_d    = ck_q;
    tc_d    = tc_q;
    span_d  = span_q;
    blend_d = blend_q;
    enter   = 1'b0;
    nk      = int'(kt_q[cm_q]);
    tc1     = (int'(tc_q) < CNT_MAX) ? tc_q + 11'd1 : tc_q;
    ck1     = ck_q + 5'd1;
    if (cmd_i.hdr && !blend_q) begin
      span_d = len_rdata;
    end
    if (cmd_i.accept && opcode_i == OP_SET && int'(motion_i) < MOTIONS) begin
      enter = 1'b1;
      cm_d  = MW'(motion_i);
    end
    if (cmd_i.accept && opcode_i == OP_START) begin
      cm_d    = neutral_idx;
      ck_d    = '0;
      tc_d    = '0;
      span_d  = '0;
      blend_d = 1'b0;
    end
    if (cmd_i.upd) begin
      tc_d = tc1;
      if (!blend_q) begin
        if (tc1 > {1'b0, klen_q}) begin
          ck_d = ck1;
          tc_d = '0;
          if (!(int'(ck1) < nk - 1)) begin
            if (!loops) begin
              enter = 1'b1;
              cm_d  = neutral_idx;
            end else if (int'(ck1) > nk - 1) begin
              ck_d = '0;
            end
          end
        end
      end else if (tc1 > {1'b0, span_q}) begin
        blend_d = 1'b0;
        tc_d    = '0;
        ck_d    = '0;
      end
    end
    if (enter) begin
      blend_d = 1'b1;
      tc_d    = '0;
      span_d  = bframes_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neutral_q <= '0;
      bframes_q <= 10'd10;
      loop_q    <= '0;
      cm_q      <= '0;
      ck_q      <= '0;
      tc_q      <= '0;
      span_q    <= '0;
      blend_q   <= 1'b0;
      part_q    <= '0;
      dcnt_q    <= '0;
      ov_q      <= 1'b0;
      for (int i = 0; i < PARTS; i++) begin
        shown_q[i] <= '0;
        start_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_NEUTRAL: neutral_q <= cfg_data_i[2:0];
          CFG_BLEND:   bframes_q <= cfg_data_i;
          CFG_LOOP:    loop_q    <= cfg_data_i[7:0];
          default:     ;
        endcase
      end
      cm_q    <= cm_d;
      ck_q    <= ck_d;
      tc_q    <= tc_d;
      span_q  <= span_d;
      blend_q <= blend_d;
      if (cmd_i.accept) begin
        part_q <= '0;
      end else if ((cmd_i.out_ld || cmd_i.start_wr) && !part_last) begin
        part_q <= part_q + PW'(1);
      end
      if (cmd_i.hdr) begin
        dcnt_q <= '0;
      end else if (cmd_i.div_step) begin
        dcnt_q <= dcnt_q + 4'd1;
      end
      if (enter) begin
        start_q <= shown_q;
      end
      if (cmd_i.start_wr) begin
        shown_q[part_q] <= pose_rdata;
        start_q[part_q] <= pose_rdata;
      end
      if (cmd_i.out_ld) begin
        shown_q[part_q] <= res_pose;
      end
      if (cmd_i.out_ld) begin
        ov_q <= 1'b1;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // weight divider: one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    logic [10:0] r2;
    r2 = {rem_q, 1'b0};
    if (cmd_i.hdr) begin
      len_q   <= blend_q ? span_q : len_rdata;
      klen_q  <= len_rdata;
      wzero_q <= ((blend_q ? span_q : len_rdata) == 10'd0);
      wsat_q  <= (tc_q >= {1'b0, (blend_q ? span_q : len_rdata)});
      rem_q   <= tc_q[9:0];
      quo_q   <= '0;
    end else if (cmd_i.div_step) begin
      if (r2 >= {1'b0, len_q}) begin
        rem_q <= 10'(r2 - {1'b0, len_q});
        quo_q <= {quo_q[10:0], 1'b1};
      end else begin
        rem_q <= r2[9:0];
        quo_q <= {quo_q[10:0], 1'b0};
      end
    end
  end

  assign w = wzero_q ? 13'd0 : (wsat_q ? 13'd4096 : {1'b0, quo_q});

  // deltas, rotation wrapped into (-pi, pi]
  always_comb begin
    logic signed [16:0] d;
    logic signed [18:0] cand;
    for (int c = 0; c < 3; c++) begin
      dpos_d[c] = $signed({pose_rdata.pos[c][19], pose_rdata.pos[c]})
                - $signed({from_q.pos[c][19], from_q.pos[c]});
      d = $signed({pose_rdata.rot[c][15], pose_rdata.rot[c]})
        - $signed({from_q.rot[c][15], from_q.rot[c]});
      drot_d[c] = '0;
      for (int j = -3; j <= 3; j++) begin
        cand = $signed({{2{d[16]}}, d}) + $signed(19'(j * TWO_PI_Q));
        if (cand > -PI_Q && cand <= PI_Q) drot_d[c] = cand[15:0];
      end
    end
  end

  // blend from pose, scaled products
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_to) begin
      from_q <= blend_q ? start_q[part_q] : pose_rdata;
    end
    if (cmd_i.take_delta) begin
      dpos_q <= dpos_d;
      drot_q <= drot_d;
    end
    if (cmd_i.take_prod) begin
      for (int c = 0; c < 3; c++) begin
        ppos_q[c] <= $signed(dpos_q[c]) * $signed({1'b0, w});
        prot_q[c] <= $signed(drot_q[c]) * $signed({1'b0, w});
      end
    end
  end

  // add and saturate
  always_comb begin
    logic signed [35:0] sp;
    logic signed [30:0] sr;
    for (int c = 0; c < 3; c++) begin
      sp = $signed(from_q.pos[c]) + (ppos_q[c] >>> 12);
      if (sp > POS_MAX) begin
        res_pose.pos[c] = 20'(POS_MAX);
      end else if (sp < POS_MIN) begin
        res_pose.pos[c] = 20'(POS_MIN);
      end else begin
        res_pose.pos[c] = sp[19:0];
      end
      sr = $signed(from_q.rot[c]) + (prot_q[c] >>> 12);
      if (sr > ROT_MAX) begin
        res_pose.rot[c] = 16'(ROT_MAX);
      end else if (sr < ROT_MIN) begin
        res_pose.rot[c] = 16'(ROT_MIN);
      end else begin
        res_pose.rot[c] = sr[15:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      opose_q  <= res_pose;
      opart_q  <= 4'(part_q);
      olast_q  <= part_last;
      omot_q   <= 3'(cm_q);
      oblend_q <= blend_q;
    end
  end

  assign sts_o.div_last  = (int'(dcnt_q) == DIV_STEPS - 1);
  assign sts_o.part_last = part_last;
  assign sts_o.out_free  = !ov_q || !out_stall_i;

  assign out_valid_o     = ov_q;
  assign out_part_o      = opart_q;
  assign out_pos_x_o     = opose_q.pos[0];
  assign out_pos_y_o     = opose_q.pos[1];
  assign out_pos_z_o     = opose_q.pos[2];
  assign out_rot_x_o     = opose_q.rot[0];
  assign out_rot_y_o     = opose_q.rot[1];
  assign out_rot_z_o     = opose_q.rot[2];
  assign last_part_o     = olast_q;
  assign active_motion_o = omot_q;
  assign blending_o      = oblend_q;

endmodule

### hdl/keyframe_pose_interpolator.sv
// Top level of the keyframe pose interpolator.
//
//   channel   direction  handshake                 payload
//   request   in         in_valid_i / in_stall_o   opcode_i .. key_total_i
//   result    out        out_valid_o / out_stall_i out_part_o .. blending_o
//   config    in         cfg_we_i                  cfg_idx_i, cfg_data_i
//
// A tick request runs a header step that reads the key length, the bit-serial
// weight divider, then the from read, to read, delta, multiply and output steps
// for each part on the single read port of the pose memory and the multiplier
// stage, and a state update step. Load and set-motion requests are taken without
// a run; start copies the neutral key 0 pose, a read and a write per part.
// Reset clears shown and blend-start poses and all sequencing state; key tables
// are undefined until loaded. A stalled result holds the part walk in place.
module keyframe_pose_interpolator #(
  parameter int PARTS   = 16,
  parameter int KEYS    = 16,
  parameter int MOTIONS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [9:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         opcode_i,
  input  logic [2:0]         motion_i,
  input  logic [3:0]         key_i,
  input  logic [3:0]         part_i,
  input  logic signed [19:0] pos_x_i,
  input  logic signed [19:0] pos_y_i,
  input  logic signed [19:0] pos_z_i,
  input  logic signed [15:0] rot_x_i,
  input  logic signed [15:0] rot_y_i,
  input  logic signed [15:0] rot_z_i,
  input  logic [9:0]         frame_count_i,
  input  logic [4:0]         key_total_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [3:0]         out_part_o,
  output logic signed [19:0] out_pos_x_o,
  output logic signed [19:0] out_pos_y_o,
  output logic signed [19:0] out_pos_z_o,
  output logic signed [15:0] out_rot_x_o,
  output logic signed [15:0] out_rot_y_o,
  output logic signed [15:0] out_rot_z_o,
  output logic               last_part_o,
  output logic [2:0]         active_motion_o,
  output logic               blending_o
);
  import kpi_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: walks header, divider, parts and update, and the start copy
  kpi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .opcode_i   (opcode_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  // datapath: tables, poses, divider and arithmetic
  kpi_dp #(.PARTS(PARTS), .KEYS(KEYS), .MOTIONS(MOTIONS)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .opcode_i        (opcode_i),
    .motion_i        (motion_i),
    .key_i           (key_i),
    .part_i          (part_i),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .pos_z_i         (pos_z_i),
    .rot_x_i         (rot_x_i),
    .rot_y_i         (rot_y_i),
    .rot_z_i         (rot_z_i),
    .frame_count_i   (frame_count_i),
    .key_total_i     (key_total_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .out_part_o      (out_part_o),
    .out_pos_x_o     (out_pos_x_o),
    .out_pos_y_o     (out_pos_y_o),
    .out_pos_z_o     (out_pos_z_o),
    .out_rot_x_o     (out_rot_x_o),
    .out_rot_y_o     (out_rot_y_o),
    .out_rot_z_o     (out_rot_z_o),
    .last_part_o     (last_part_o),
    .active_motion_o (active_motion_o),
    .blending_o      (blending_o)
  );

`ifndef SYNTHESIS
  // the final result of a run carries the last part index
  a_last_part: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_part_o |-> out_part_o == 4'(PARTS - 1))
    else $error("last_part on wrong part");

  // mid-run results mean the part walk still holds the request side
  a_run_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_part_o |-> in_stall_o)
    else $error("request taken during a part run");

  // an accepted tick always starts a multi-cycle run
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && opcode_i == OP_TICK |=> in_stall_o)
    else $error("tick did not start a run");
`endif

endmodule

### bench/keyframe_pose_interpolator_test.sv
// Self-checking bench for the keyframe pose interpolator with a built-in pose predictor.
`timescale 1ns / 1ps

module keyframe_pose_interpolator_test;
  import kpi_pkg::*;

  localparam int NPARTS    = 16;
  localparam int NKEYS     = 16;
  localparam int NMOTIONS  = 8;
  localparam int IDLE_LIMIT = 4000;
  localparam int SETTLE     = 150;

  // One request as it goes over the input channel.
  typedef struct {
    logic [2:0]         op;
    logic [2:0]         mot;
    logic [3:0]         key;
    logic [3:0]         part;
    logic signed [19:0] px, py, pz;
    logic signed [15:0] rx, ry, rz;
    logic [9:0]         frames;
    logic [4:0]         ktot;
  } request_t;

  // One interpolated pose as it comes out of the block.
  typedef struct packed {
    logic [3:0]       part;
    logic [2:0][19:0] pos;
    logic [2:0][15:0] rot;
    logic             last;
    logic [2:0]       motion;
    logic             blend;
  } part_pose_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [9:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [2:0] opcode_i = '0;
  logic [2:0] motion_i = '0;
  logic [3:0] key_i = '0;
  logic [3:0] part_i = '0;
  logic signed [19:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic signed [15:0] rot_x_i = '0, rot_y_i = '0, rot_z_i = '0;
  logic [9:0] frame_count_i = '0;
  logic [4:0] key_total_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [3:0] out_part_o;
  logic signed [19:0] out_pos_x_o, out_pos_y_o, out_pos_z_o;
  logic signed [15:0] out_rot_x_o, out_rot_y_o, out_rot_z_o;
  logic last_part_o;
  logic [2:0] active_motion_o;
  logic blending_o;

  keyframe_pose_interpolator i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Requests still to be sent and poses still to be seen.
  request_t   pending_q[$];
  part_pose_t poses_due_q[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // Append a request to the pending list.
  function automatic void add_request(request_t rq);
    pending_q.insert(pending_q.size(), rq);
  endfunction

  // Predictor state: key tables, shown and blend-start poses, sequencing.
  logic [2:0][19:0] key_pos[NMOTIONS*NKEYS*NPARTS];
  logic [2:0][15:0] key_rot[NMOTIONS*NKEYS*NPARTS];
  int unsigned key_len[NMOTIONS*NKEYS];
  int unsigned key_count[NMOTIONS];
  logic [2:0][19:0] shown_pos[NPARTS], from_pos[NPARTS];
  logic [2:0][15:0] shown_rot[NPARTS], from_rot[NPARTS];
  int unsigned cur_motion = 0, cur_key = 0, tick_cnt = 0, span_len = 0;
  bit blend_on = 1'b0;
  int unsigned neutral_reg = 0, blend_reg = 10, loop_reg = 0;

  // Key totals used by the stimulus; every key below a motion's total (key 0
  // at least) is loaded, so no tick ever reads an unloaded entry.
  int unsigned play_keys[NMOTIONS] = '{2, 1, 0, 1, 1, 3, 1, 1};

  function automatic int pose_idx(int m, int k, int p);
    return (m * NKEYS + k) * NPARTS + p;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic void begin_blend(int unsigned m);
    from_pos = shown_pos;
    from_rot = shown_rot;
    cur_motion = m;
    blend_on = 1'b1;
    tick_cnt = 0;
    span_len = blend_reg;
  endfunction

  // One tick: interpolate every part, queue the poses, then advance the key.
  function automatic void interpolate_tick();
    int m, nk, kidx, nxt, len, p, c, src, dst;
    longint unsigned q;
    longint w, f, t, d, v;
    bit was_blend;
    part_pose_t r;
    m = cur_motion;
    nk = key_count[m];
    kidx = cur_key < NKEYS ? cur_key : NKEYS - 1;
    nxt = (int'(cur_key) >= nk - 1) ? 0 : cur_key + 1;
    if (nxt >= NKEYS) nxt = NKEYS - 1;
    was_blend = blend_on;
    if (blend_on) begin
      nxt = 0;
      len = span_len;
    end else begin
      span_len = key_len[m*NKEYS + kidx];
      len = span_len;
    end
    if (len == 0) w = 0;
    else begin
      q = (longint'(tick_cnt) * 4096) / len;
      w = q > 4096 ? 4096 : q;
    end
    for (p = 0; p < NPARTS; p++) begin
      src = pose_idx(m, kidx, p);
      dst = pose_idx(m, nxt, p);
      for (c = 0; c < 3; c++) begin
        f = was_blend ? $signed(from_pos[p][c]) : $signed(key_pos[src][c]);
        t = $signed(key_pos[dst][c]);
        v = clip(f + (((t - f) * w) >>> 12), POS_MIN, POS_MAX);
        shown_pos[p][c] = v[19:0];
        r.pos[c] = v[19:0];
        f = was_blend ? $signed(from_rot[p][c]) : $signed(key_rot[src][c]);
        t = $signed(key_rot[dst][c]);
        // wrap the angle step into (-pi, pi]
        d = t - f;
        while (d <= -PI_Q) d += TWO_PI_Q;
        while (d > PI_Q) d -= TWO_PI_Q;
        v = clip(f + ((d * w) >>> 12), ROT_MIN, ROT_MAX);
        shown_rot[p][c] = v[15:0];
        r.rot[c] = v[15:0];
      end
      r.part = 4'(p);
      r.last = (p == NPARTS - 1);
      r.motion = 3'(m);
      r.blend = was_blend;
      poses_due_q.insert(poses_due_q.size(), r);
    end
    if (tick_cnt < CNT_MAX) tick_cnt++;
    if (!was_blend) begin
      if (tick_cnt > key_len[m*NKEYS + kidx]) begin
        cur_key = (cur_key + 1) & 31;
        if (!(int'(cur_key) < nk - 1)) begin
          if (!loop_reg[m]) begin_blend(neutral_reg);
          else if (int'(cur_key) > nk - 1) cur_key = 0;
        end
        tick_cnt = 0;
      end
    end else if (tick_cnt > span_len) begin
      blend_on = 1'b0;
      tick_cnt = 0;
      cur_key = 0;
    end
  endfunction

  // Apply one accepted request to the predictor.
  function automatic void predict_request(request_t rq);
    int i, p;
    case (rq.op)
      OP_TICK: interpolate_tick();
      OP_POSE: begin
        i = pose_idx(rq.mot, rq.key, rq.part);
        key_pos[i] = {rq.pz, rq.py, rq.px};
        key_rot[i] = {rq.rz, rq.ry, rq.rx};
      end
      OP_HDR: begin
        key_len[rq.mot*NKEYS + rq.key] = rq.frames;
        key_count[rq.mot] = rq.ktot > NKEYS ? NKEYS : rq.ktot;
      end
      OP_START: begin
        for (p = 0; p < NPARTS; p++) begin
          i = pose_idx(neutral_reg, 0, p);
          shown_pos[p] = key_pos[i];
          shown_rot[p] = key_rot[i];
          from_pos[p] = key_pos[i];
          from_rot[p] = key_rot[i];
        end
        cur_motion = neutral_reg;
        cur_key = 0;
        tick_cnt = 0;
        span_len = 0;
        blend_on = 1'b0;
      end
      OP_SET: begin_blend(rq.mot);
      default: ;
    endcase
  endfunction

  // Driver: advance to the next request once the current one is taken.
  always @(posedge clk_i) begin
    if (rst_ni && (!in_valid_i || !in_stall_o)) begin
      if (in_valid_i) begin
        predict_request('{opcode_i, motion_i, key_i, part_i, pos_x_i, pos_y_i, pos_z_i,
                          rot_x_i, rot_y_i, rot_z_i, frame_count_i, key_total_i});
      end
      if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        request_t rq;
        rq = pending_q.pop_front();
        in_valid_i <= 1'b1;
        opcode_i <= rq.op;
        motion_i <= rq.mot;
        key_i <= rq.key;
        part_i <= rq.part;
        pos_x_i <= rq.px;
        pos_y_i <= rq.py;
        pos_z_i <= rq.pz;
        rot_x_i <= rq.rx;
        rot_y_i <= rq.ry;
        rot_z_i <= rq.rz;
        frame_count_i <= rq.frames;
        key_total_i <= rq.ktot;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  task automatic check(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // Monitor: stall at random, compare each taken pose with the oldest one due.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      if (out_valid_o && !out_stall_i) begin
        if (poses_due_q.size() == 0) begin
          $display("%0t: unexpected pose expected none actual part %0d", $time, out_part_o);
          errors++;
        end else begin
          part_pose_t e;
          e = poses_due_q.pop_front();
          check("part", e.part, out_part_o);
          check("pos_x", $signed(e.pos[0]), out_pos_x_o);
          check("pos_y", $signed(e.pos[1]), out_pos_y_o);
          check("pos_z", $signed(e.pos[2]), out_pos_z_o);
          check("rot_x", $signed(e.rot[0]), out_rot_x_o);
          check("rot_y", $signed(e.rot[1]), out_rot_y_o);
          check("rot_z", $signed(e.rot[2]), out_rot_z_o);
          check("last_part", e.last, last_part_o);
          check("active_motion", e.motion, active_motion_o);
          check("blending", e.blend, blending_o);
        end
      end
    end
  end

  // Watchdog: drop the run if nothing moves for too long.
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic signed [19:0] pick_pos();
    case ($urandom_range(3))
      0: return 20'(POS_MAX);
      1: return 20'(POS_MIN);
      default: return 20'($urandom);
    endcase
  endfunction

  function automatic logic signed [15:0] pick_rot();
    case ($urandom_range(3))
      0: return 16'(ROT_MAX);
      1: return 16'(ROT_MIN);
      default: return 16'($urandom);
    endcase
  endfunction

  // Request with random filler in the fields the opcode does not use.
  function automatic request_t make_req(logic [2:0] op, int m, int k);
    request_t rq;
    rq.op = op;
    rq.mot = 3'(m);
    rq.key = 4'(k);
    rq.part = 4'($urandom);
    rq.px = pick_pos();
    rq.py = pick_pos();
    rq.pz = pick_pos();
    rq.rx = pick_rot();
    rq.ry = pick_rot();
    rq.rz = pick_rot();
    rq.frames = ($urandom_range(99) < 4) ? 10'($urandom) : 10'($urandom_range(5));
    rq.ktot = 5'($urandom);
    return rq;
  endfunction

  // Header request that keeps the motion's key total as played.
  function automatic request_t make_hdr(int m, int k);
    request_t rq;
    rq = make_req(OP_HDR, m, k);
    rq.ktot = 5'(play_keys[m]);
    return rq;
  endfunction

  function automatic request_t make_random_req();
    int roll, m;
    roll = $urandom_range(99);
    m = $urandom_range(NMOTIONS - 1);
    if (roll < 50) return make_req(OP_TICK, m, $urandom);
    if (roll < 68) return make_req(OP_POSE, m, $urandom);
    if (roll < 76) return make_hdr(m, $urandom_range(play_keys[m] > 2 ? play_keys[m] - 1 : 1));
    if (roll < 88) return make_req(OP_SET, m, $urandom);
    if (roll < 94) return make_req(OP_START, m, $urandom);
    return make_req(3'($urandom_range(5, 7)), m, $urandom);
  endfunction

  task automatic write_reg(logic [1:0] idx, int unsigned value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= 10'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_NEUTRAL: neutral_reg = value & 7;
      CFG_BLEND:   blend_reg = value & 1023;
      CFG_LOOP:    loop_reg = value & 255;
      default: ;
    endcase
  endtask

  // Hold until every request is taken and every pose has come out, then let
  // a trailing start copy finish.
  task automatic drain();
    while (pending_q.size() > 0 || in_valid_i || poses_due_q.size() > 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic random_phase(int n, int unsigned neutral, int unsigned blend,
                              int unsigned loops, int idle, int stall);
    write_reg(CFG_NEUTRAL, neutral | ($urandom_range(127) << 3));
    write_reg(CFG_BLEND, blend);
    write_reg(CFG_LOOP, loops | ($urandom_range(3) << 8));
    send_idle_pct = idle;
    recv_stall_pct = stall;
    add_request(make_req(OP_START, 0, 0));
    repeat (n) add_request(make_random_req());
    drain();
  endtask

  initial begin
    int m, k, p;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Load the tables: a header for every played key (key 0 at least), each
    // carrying the key total, then every pose of those keys.
    for (m = 0; m < NMOTIONS; m++) begin
      for (k = 0; k < (play_keys[m] > 1 ? play_keys[m] : 1); k++)
        add_request(make_hdr(m, k));
      for (k = 0; k < (play_keys[m] > 1 ? play_keys[m] : 1); k++)
        for (p = 0; p < NPARTS; p++) begin
          request_t rq;
          rq = make_req(OP_POSE, m, k);
          rq.part = 4'(p);
          add_request(rq);
        end
    end
    drain();

    // Directed: zero key length, oversize and full key totals, empty motion,
    // blends into the highest motion, ignored opcodes, restart from neutral.
    begin
      request_t rq;
      rq = make_hdr(0, 0);
      rq.frames = 0;
      add_request(rq);
      rq = make_req(OP_HDR, 7, 15);
      rq.frames = 10'h3ff;
      rq.ktot = 5'd31;
      add_request(rq);
      rq = make_req(OP_HDR, 7, 1);
      rq.ktot = 5'd16;
      add_request(rq);
      add_request(make_hdr(7, 1));
    end
    add_request(make_req(OP_START, 0, 0));
    repeat (4) add_request(make_req(OP_TICK, 0, 0));
    add_request(make_req(OP_SET, 7, 0));
    repeat (3) add_request(make_req(OP_TICK, 0, 0));
    add_request(make_req(OP_SET, 2, 0));
    repeat (3) add_request(make_req(OP_TICK, 0, 0));
    add_request(make_req(3'd5, 0, 0));
    add_request(make_req(3'd6, 7, 15));
    add_request(make_req(3'd7, 7, 15));
    add_request(make_req(OP_START, 0, 0));
    repeat (2) add_request(make_req(OP_TICK, 0, 0));
    drain();

    // Random phases under different settings and traffic shapes.
    random_phase(19, 7, 1, 8'hff, 0, 0);
    random_phase(19, 3, 0, 8'h55, 51, 0);
    random_phase(19, 0, 1023, 8'h00, 0, 51);
    random_phase(19, 5, 3, 8'haa, 21, 21);
    random_phase(19, 2, 2, 8'h0f, 21, 21);

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
